// File: sv/bae_pkg.sv
// shared constants, register indexes and control structs for the block average / ema block
// no dependencies
`timescale 1ns / 1ps

package bae_pkg;

	localparam int MAX_WINDOW = 64;
	localparam int CNT_W      = 7;
	localparam int SUM_W      = 38;
	localparam int DIV_W      = 38;
	localparam int DEN_W      = 8;
	localparam int ALPHA_W    = 17;
	localparam int CFG_W      = 17;

	localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);
	localparam logic [DIV_W-1:0]   FORCE_NUM = DIV_W'(131072);

	localparam logic [1:0] REG_WINDOW    = 2'd0;
	localparam logic [1:0] REG_SCALE     = 2'd1;
	localparam logic [1:0] REG_ALPHA_MIN = 2'd2;
	localparam logic [1:0] REG_ALPHA_MAX = 2'd3;

	typedef struct packed {
		logic take;
		logic accum;
		logic div_avg;
		logic div_alpha;
		logic set_avg;
		logic set_falpha;
		logic zero_avg;
		logic calc_delta;
		logic calc_alpha;
		logic calc_mul;
		logic upd_ema;
		logic clr_block;
		logic load_out;
	} bae_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic div_busy;
		logic div_done;
		logic out_free;
	} bae_sts_t;

endpackage

// File: sv/bae_div.sv
// iterative restoring divider, one quotient bit per cycle
// depends on bae_pkg
`timescale 1ns / 1ps

module bae_div import bae_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic             busy,
	output logic             done,
	output logic [DIV_W-1:0] quotient
);

	localparam int STEP_W = $clog2(DIV_W);

	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DIV_W-1:0]  quo_q;
	logic [DEN_W-1:0]  dsr_q;
	logic [DEN_W:0]    trial;
	logic              fits;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && !start && step_q == STEP_W'(DIV_W - 1);
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(DIV_W - 1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? DEN_W'(trial - {1'b0, dsr_q}) : trial[DEN_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: sv/bae_dp.sv
// datapath: config registers, block sum and count, ema state, alpha math, output register
// depends on bae_pkg and bae_div
`timescale 1ns / 1ps

module bae_dp import bae_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  bae_cmd_t         cmd,
	output bae_sts_t         sts,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_addr,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic [31:0]      sample,
	input  logic             out_ready,
	output logic             out_valid,
	output logic [31:0]      out_avg,
	output logic [31:0]      out_ema,
	output logic             out_blk
);

	logic [CNT_W-1:0]   win_q;
	logic [15:0]        scale_q;
	logic [ALPHA_W-1:0] amin_q;
	logic [ALPHA_W-1:0] amax_q;

	logic signed [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0]        cnt_q;
	logic signed [31:0]      ema_q;
	logic                    seeded_q;
	logic                    rdy_q;
	logic signed [31:0]      avg_q;
	logic [48:0]             prod_q;
	logic [ALPHA_W-1:0]      alpha_q;
	logic signed [50:0]      mul_q;
	logic                    ov_q;
	logic [31:0]             oavg_q;
	logic [31:0]             oema_q;
	logic                    oblk_q;

	logic [CNT_W-1:0]   win_eff;
	logic [SUM_W-1:0]   mag;
	logic [DEN_W-1:0]   den;
	logic [DIV_W-1:0]   div_dvd;
	logic [DEN_W-1:0]   div_dsr;
	logic               div_start;
	logic               div_busy;
	logic               div_done;
	logic [DIV_W-1:0]   div_quo;
	logic [31:0]        avg_next;
	logic signed [32:0] diff;
	logic [32:0]        absd;
	logic [32:0]        delta;
	logic [48:0]        prod_next;
	logic [32:0]        a_raw;
	logic [ALPHA_W-1:0] a_clamp;
	logic [ALPHA_W-1:0] a_sat;
	logic signed [50:0] mul_next;
	logic signed [50:0] rnd;
	logic signed [50:0] step;
	logic               clear;

	assign win_eff = (win_q == '0 || win_q > CNT_W'(MAX_WINDOW)) ? CNT_W'(MAX_WINDOW) : win_q;
	assign mag     = sum_q[SUM_W-1] ? (~sum_q + 1'b1) : sum_q;
	assign den     = {1'b0, cnt_q} + DEN_W'(1);

	assign div_start = cmd.div_avg | cmd.div_alpha;
	assign div_dvd   = cmd.div_alpha ? (FORCE_NUM + {31'd0, den[DEN_W-1:1]})
	                                 : (mag + {32'd0, cnt_q[CNT_W-1:1]});
	assign div_dsr   = cmd.div_alpha ? den : {1'b0, cnt_q};

	bae_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign avg_next = sum_q[SUM_W-1] ? (~div_quo[31:0] + 32'd1) : div_quo[31:0];

	assign diff      = {avg_q[31], avg_q} - {ema_q[31], ema_q};
	assign absd      = diff[32] ? (~diff + 1'b1) : diff;
	assign delta     = seeded_q ? absd : '0;
	assign prod_next = {33'd0, scale_q} * {16'd0, delta};

	assign a_raw = prod_q[48:16];
	always_comb begin
		priority if (a_raw < {16'd0, amin_q})
			a_clamp = amin_q;
		else if (a_raw > {16'd0, amax_q})
			a_clamp = amax_q;
		else
			a_clamp = a_raw[ALPHA_W-1:0];
	end
	assign a_sat = (a_clamp > ALPHA_ONE) ? ALPHA_ONE : a_clamp;

	assign mul_next = 51'(diff) * 51'($signed({1'b0, alpha_q}));
	assign rnd      = mul_q + 51'sd32768;
	assign step     = rnd >>> 16;

	assign clear = cfg_we && cfg_addr == REG_WINDOW;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= CNT_W'(64);
			scale_q <= 16'd3277;
			amin_q  <= ALPHA_W'(6554);
			amax_q  <= ALPHA_W'(26214);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_WINDOW:    win_q   <= cfg_data[CNT_W-1:0];
				REG_SCALE:     scale_q <= cfg_data[15:0];
				REG_ALPHA_MIN: amin_q  <= cfg_data[ALPHA_W-1:0];
				REG_ALPHA_MAX: amax_q  <= cfg_data[ALPHA_W-1:0];
				default: ;
			endcase
		end
	end

	// filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			cnt_q    <= '0;
			ema_q    <= '0;
			seeded_q <= 1'b0;
			rdy_q    <= 1'b0;
		end else if (clear) begin
			sum_q    <= '0;
			cnt_q    <= '0;
			ema_q    <= '0;
			seeded_q <= 1'b0;
		end else begin
			if (cmd.take)
				rdy_q <= 1'b0;
			if (cmd.accum) begin
				sum_q <= sum_q + SUM_W'($signed(sample));
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.upd_ema) begin
				seeded_q <= 1'b1;
				ema_q    <= seeded_q ? (ema_q + step[31:0]) : avg_q;
			end
			if (cmd.clr_block) begin
				sum_q <= '0;
				cnt_q <= '0;
				rdy_q <= 1'b1;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.set_avg)
			avg_q <= avg_next;
		else if (cmd.zero_avg)
			avg_q <= '0;
		if (cmd.calc_delta)
			prod_q <= prod_next;
		if (cmd.set_falpha)
			alpha_q <= div_quo[ALPHA_W-1:0];
		else if (cmd.calc_alpha)
			alpha_q <= a_sat;
		if (cmd.calc_mul)
			mul_q <= mul_next;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.load_out) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			oavg_q <= avg_q;
			oema_q <= ema_q;
			oblk_q <= rdy_q;
		end
	end

	assign sts.empty    = cnt_q == '0;
	assign sts.full     = cnt_q >= win_eff;
	assign sts.div_busy = div_busy;
	assign sts.div_done = div_done;
	assign sts.out_free = !ov_q || out_ready;

	assign out_valid = ov_q;
	assign out_avg   = oavg_q;
	assign out_ema   = oema_q;
	assign out_blk   = oblk_q;

endmodule

// File: sv/bae_ctrl.sv
// controller state machine sequencing sample, block close and force requests
// depends on bae_pkg
`timescale 1ns / 1ps

module bae_ctrl import bae_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_force,
	output logic     in_ready,
	input  bae_sts_t sts,
	output bae_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_AVG,
		ST_DELTA,
		ST_ALPHA,
		ST_MUL,
		ST_UPD,
		ST_FALPHA,
		ST_FAVG,
		ST_RESULT
	} state_t;

	state_t state_q;
	logic   force_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			force_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						force_q <= in_force;
						if (!in_force)
							state_q <= ST_START;
						else if (sts.empty)
							state_q <= ST_RESULT;
						else
							state_q <= ST_FALPHA;
					end
				end
				ST_START:  state_q <= ST_AVG;
				ST_AVG: begin
					if (sts.div_done)
						state_q <= sts.full ? ST_DELTA : ST_RESULT;
				end
				ST_DELTA:  state_q <= ST_ALPHA;
				ST_ALPHA:  state_q <= ST_MUL;
				ST_MUL:    state_q <= ST_UPD;
				ST_UPD:    state_q <= ST_RESULT;
				ST_FALPHA: begin
					if (sts.div_done)
						state_q <= ST_FAVG;
				end
				ST_FAVG: begin
					if (sts.div_done)
						state_q <= ST_MUL;
				end
				ST_RESULT: begin
					if (sts.out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready = state_q == ST_IDLE;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					if (!in_force)
						cmd.accum = 1'b1;
					else if (sts.empty)
						cmd.zero_avg = 1'b1;
					else
						cmd.div_alpha = 1'b1;
				end
			end
			ST_START:  cmd.div_avg = 1'b1;
			ST_AVG:    cmd.set_avg = sts.div_done;
			ST_DELTA:  cmd.calc_delta = 1'b1;
			ST_ALPHA:  cmd.calc_alpha = 1'b1;
			ST_MUL:    cmd.calc_mul = 1'b1;
			ST_UPD: begin
				cmd.upd_ema   = 1'b1;
				cmd.clr_block = !force_q;
			end
			ST_FALPHA: begin
				cmd.set_falpha = sts.div_done;
				cmd.div_avg    = sts.div_done;
			end
			ST_FAVG:   cmd.set_avg = sts.div_done;
			ST_RESULT: cmd.load_out = sts.out_free;
			default: ;
		endcase
	end

endmodule

// File: sv/block_average_adaptive_ema.sv
// top level of the block average with adaptive ema filter
// depends on bae_pkg, bae_ctrl and bae_dp
//
//   channel   | dir | handshake         | payload
//   s_*       | in  | s_tvalid/s_tready | tdata: sample; tuser: cmd
//   m_*       | out | m_tvalid/m_tready | tdata: block_avg, ema; tlast: block_ready
//   cfg_*     | in  | cfg_we            | cfg_addr: register index; cfg_data: value
//
// a sample request makes one pass through the 38-step shared divider; a force makes two, or
// none when the block is empty; one request is worked at a time, and the next is taken
// while the result waits in the output reg; writing window_size clears the filter
// arst_n clears control, filter and output valid state and loads register defaults
`timescale 1ns / 1ps

module block_average_adaptive_ema import bae_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [31:0]      s_tdata,   // [31:0] sample
	input  logic             s_tuser,   // [0] cmd
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [63:0]      m_tdata,   // [31:0] block_avg, [63:32] ema
	output logic             m_tlast,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_addr,
	input  logic [CFG_W-1:0] cfg_data
);

	bae_cmd_t    cmd;
	bae_sts_t    sts;
	logic [31:0] out_avg;
	logic [31:0] out_ema;

	bae_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_force (s_tuser),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bae_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.sample    (s_tdata),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_avg   (out_avg),
		.out_ema   (out_ema),
		.out_blk   (m_tlast)
	);

	assign m_tdata = {out_ema, out_avg};

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_avg || cmd.div_alpha) |-> !sts.div_busy)
		else $error("divider started while busy");

	a_accept_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !sts.div_busy)
		else $error("request accepted during a division");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!m_tvalid || m_tready))
		else $error("output register overwritten before taken");

endmodule
